>>> design/lz78_pkg.sv
// ----------------------------------------------------------------------------
// lz78_pkg
// Shared types, constants and controller/datapath interface for the LZ78
// byte encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lz78_pkg;

    localparam int CODE_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int KEY_W    = CODE_W + BYTE_W;
    localparam int EPOCH_W  = 8;
    localparam int WORD_W   = EPOCH_W + CODE_W + KEY_W;
    localparam int HASH_W   = 32;

    localparam int DICT_LIMIT_DEF  = 4096;
    localparam int TABLE_DEPTH_DEF = 8192;

    localparam logic [HASH_W-1:0]  HASH_MULT = 32'd2654435761;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_data;
    } src_t;

    typedef struct packed {
        logic [CODE_W-1:0] phrase_code;
        logic [BYTE_W-1:0] next_symbol;
        logic              symbol_present;
        logic              final_token;
    } dst_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_SLOT,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic do_hash;
        logic start_slot;
        logic mod_run;
        logic rd_en;
        logic probe_next;
        logic commit;
        logic wipe_write;
        logic emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic slot_ready;
        logic mod_done;
        logic hit;
        logic empty;
        logic probe_last;
        logic eod;
        logic wipe_req;
        logic wipe_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> design/lz78_ram.sv
// ----------------------------------------------------------------------------
// lz78_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lz78_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/lz78_ctrl.sv
// ----------------------------------------------------------------------------
// lz78_ctrl
// Sequencer: accept, hash, slot reduction, probe loop, result hand-off and
// dictionary wipe.
// ----------------------------------------------------------------------------
`default_nettype none

module lz78_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   ready,
    output lz78_pkg::cmd_t         cmd,
    input  wire lz78_pkg::status_t status
);

    import lz78_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ready      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.wipe_write = 1'b1;
                if (status.wipe_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ready = 1'b1;
                if (src_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_HASH;
                end
            end
            ST_HASH:
            begin
                cmd.do_hash = 1'b1;
                state_next  = ST_SLOT;
            end
            ST_SLOT:
            begin
                cmd.start_slot = 1'b1;
                state_next     = status.slot_ready ? ST_READ : ST_MOD;
            end
            ST_MOD:
            begin
                cmd.mod_run = 1'b1;
                if (status.mod_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.hit && !status.eod)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.hit || status.empty || status.probe_last)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.wipe_req ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/lz78_dp.sv
// ----------------------------------------------------------------------------
// lz78_dp
// Datapath: phrase/code/epoch registers, multiplicative hash, slot
// reduction, dictionary RAM and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lz78_dp #(
    parameter int DICT_LIMIT  = lz78_pkg::DICT_LIMIT_DEF,
    parameter int TABLE_DEPTH = lz78_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lz78_pkg::src_t    src_data,
    output logic                   dst_valid,
    input  wire logic              dst_stall,
    output lz78_pkg::dst_t         dst_data,
    input  wire lz78_pkg::cmd_t    cmd,
    output lz78_pkg::status_t      status
);

    import lz78_pkg::*;

    localparam int  SW      = $clog2(TABLE_DEPTH);
    localparam bit  IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [SW-1:0]     LAST_SLOT = SW'(TABLE_DEPTH - 1);
    localparam logic [CODE_W-1:0] LIMIT     = CODE_W'(DICT_LIMIT);

    logic [CODE_W-1:0]  phrase_reg;
    logic [CODE_W-1:0]  next_code_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic               wipe_req_reg;
    logic [SW-1:0]      wipe_cnt_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic               eod_reg;
    logic [HASH_W-1:0]  prod_reg;
    logic [SW-1:0]      slot_reg;
    logic [SW-1:0]      probe_cnt_reg;
    dst_t               pend_reg;
    dst_t               dst_data_reg;
    logic               dst_valid_reg;

    logic [KEY_W-1:0]   key;
    logic [HASH_W-1:0]  mix;
    logic [SW-1:0]      mod_rem;
    logic               mod_done;
    logic [WORD_W-1:0]  rdata;
    logic [EPOCH_W-1:0] rd_tag;
    logic [CODE_W-1:0]  rd_code;
    logic [KEY_W-1:0]   rd_key;
    logic               entry_valid;
    logic               hit;
    logic [CODE_W-1:0]  code_inc;
    logic               do_clear;
    logic               insert_we;
    logic               ram_we;
    logic [SW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [SW-1:0]      slot_inc;

    assign key      = {phrase_reg, byte_reg};
    assign mix      = prod_reg ^ (prod_reg >> 15);
    assign slot_inc = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    // slot = mix mod TABLE_DEPTH
    generate
        if (IS_POW2)
        begin : g_mask
            assign mod_rem  = mix[SW-1:0];
            assign mod_done = 1'b1;
        end
        else
        begin : g_recip
            // reciprocal estimate of the quotient is at most one low, so a
            // single compare-subtract on the registered partial remainder finishes
            localparam logic [HASH_W-1:0] RECIP =
                HASH_W'((64'd1 << HASH_W) / 64'(TABLE_DEPTH));
            localparam logic [HASH_W-1:0] DEPTH_W = HASH_W'(TABLE_DEPTH);

            logic [HASH_W-1:0]   mix_hold_reg;
            logic [HASH_W-1:0]   quot_reg;
            logic [SW:0]         part_reg;
            logic [1:0]          step_reg;
            logic [2*HASH_W-1:0] recip_prod;
            logic [HASH_W-1:0]   part_full;

            assign recip_prod = {{HASH_W{1'b0}}, mix_hold_reg} *
                                {{HASH_W{1'b0}}, RECIP};
            assign part_full  = mix_hold_reg - quot_reg * DEPTH_W;
            assign mod_rem    = (part_reg >= (SW+1)'(TABLE_DEPTH)) ?
                                SW'(part_reg - (SW+1)'(TABLE_DEPTH)) :
                                part_reg[SW-1:0];
            assign mod_done   = (step_reg == 2'd2);

            always_ff @(posedge clk)
            begin
                if (cmd.start_slot)
                begin
                    mix_hold_reg <= mix;
                    step_reg     <= 2'd0;
                end
                else if (cmd.mod_run)
                begin
                    if (step_reg == 2'd0)
                    begin
                        quot_reg <= recip_prod[2*HASH_W-1 -: HASH_W];
                    end
                    if (step_reg == 2'd1)
                    begin
                        part_reg <= part_full[SW:0];
                    end
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    endgenerate

    assign rd_tag      = rdata[WORD_W-1 -: EPOCH_W];
    assign rd_code     = rdata[KEY_W +: CODE_W];
    assign rd_key      = rdata[KEY_W-1:0];
    assign entry_valid = (rd_tag == epoch_reg);
    assign hit         = entry_valid && (rd_key == key);
    assign code_inc    = next_code_reg + 1'b1;
    assign do_clear    = eod_reg || (!hit && (code_inc == LIMIT));
    assign insert_we   = cmd.commit && !entry_valid;

    assign ram_we    = cmd.wipe_write || insert_we;
    assign ram_waddr = cmd.wipe_write ? wipe_cnt_reg : slot_reg;
    assign ram_wdata = cmd.wipe_write ? '0 : {epoch_reg, next_code_reg, key};

    lz78_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_dict (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phrase_reg    <= '0;
            next_code_reg <= CODE_W'(1);
            epoch_reg     <= EPOCH_FIRST;
            wipe_req_reg  <= 1'b1;
            wipe_cnt_reg  <= '0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wipe_write)
            begin
                wipe_cnt_reg <= (wipe_cnt_reg == LAST_SLOT) ? '0 : wipe_cnt_reg + 1'b1;
                if (wipe_cnt_reg == LAST_SLOT)
                begin
                    wipe_req_reg <= 1'b0;
                end
            end
            if (cmd.commit)
            begin
                phrase_reg <= (hit && !eod_reg) ? rd_code : '0;
                if (do_clear)
                begin
                    next_code_reg <= CODE_W'(1);
                    if (epoch_reg == EPOCH_MAX)
                    begin
                        epoch_reg    <= EPOCH_FIRST;
                        wipe_req_reg <= 1'b1;
                    end
                    else
                    begin
                        epoch_reg <= epoch_reg + 1'b1;
                    end
                end
                else if (!hit)
                begin
                    next_code_reg <= code_inc;
                end
            end
            if (cmd.emit)
            begin
                dst_valid_reg <= 1'b1;
            end
            else if (!dst_stall)
            begin
                dst_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            byte_reg <= src_data.data_byte;
            eod_reg  <= src_data.end_of_data;
        end
        if (cmd.do_hash)
        begin
            prod_reg <= {{(HASH_W-KEY_W){1'b0}}, key} * HASH_MULT;
        end
        if (cmd.start_slot)
        begin
            probe_cnt_reg <= '0;
            if (IS_POW2)
            begin
                slot_reg <= mod_rem;
            end
        end
        else if (cmd.mod_run && mod_done)
        begin
            slot_reg <= mod_rem;
        end
        else if (cmd.probe_next)
        begin
            slot_reg      <= slot_inc;
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end
        if (cmd.commit)
        begin
            if (hit)
            begin
                pend_reg.phrase_code    <= rd_code;
                pend_reg.next_symbol    <= '0;
                pend_reg.symbol_present <= 1'b0;
                pend_reg.final_token    <= 1'b1;
            end
            else
            begin
                pend_reg.phrase_code    <= phrase_reg;
                pend_reg.next_symbol    <= byte_reg;
                pend_reg.symbol_present <= 1'b1;
                pend_reg.final_token    <= eod_reg;
            end
        end
        if (cmd.emit)
        begin
            dst_data_reg <= pend_reg;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

    assign status.slot_ready = IS_POW2;
    assign status.mod_done   = mod_done;
    assign status.hit        = hit;
    assign status.empty      = !entry_valid;
    assign status.probe_last = (probe_cnt_reg == LAST_SLOT);
    assign status.eod        = eod_reg;
    assign status.wipe_req   = wipe_req_reg;
    assign status.wipe_last  = (wipe_cnt_reg == LAST_SLOT);
    assign status.out_free   = !dst_valid_reg || !dst_stall;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!dst_valid_reg || !dst_stall))
        else $error("result register overwritten while held");
    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch reached the wiped tag value");
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_code_reg != '0) && (next_code_reg < LIMIT))
        else $error("next code out of range");
    a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wipe_write && insert_we))
        else $error("insert collided with wipe");
`endif

endmodule

`default_nettype wire

>>> design/lz78_byte_encoder_top.sv
// ----------------------------------------------------------------------------
// lz78_byte_encoder_top
// LZ78 byte compressor: one byte per input transaction, at most one token
// per output transaction.
// ----------------------------------------------------------------------------
// A byte goes through accept, hash multiply, slot reduction, then one RAM
// read plus compare per probe of the linear-probing dictionary. Slot
// reduction is a mask with a power-of-two TABLE_DEPTH and a reciprocal
// remainder otherwise; a token then moves into the output register. The
// dictionary RAM has one read and one write port, which sets the
// per-probe cost. Entries carry an 8-bit epoch tag, so a dictionary
// flush (code limit reached or end of data) is just an epoch bump; every
// 255th flush, and once after reset, a clearing pass over all TABLE_DEPTH
// slots rewrites the tags while src_stall is held high.
// A token waiting on dst_stall does not block acceptance of the next byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lz78_byte_encoder_top #(
    parameter int DICT_LIMIT  = lz78_pkg::DICT_LIMIT_DEF,
    parameter int TABLE_DEPTH = lz78_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           src_valid,
    output logic                src_stall,
    input  wire lz78_pkg::src_t src_data,
    output logic                dst_valid,
    input  wire logic           dst_stall,
    output lz78_pkg::dst_t      dst_data
);

    import lz78_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    ready;

    // input side is open only between items
    assign src_stall = !ready;

    lz78_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .ready     (ready),
        .cmd       (cmd),
        .status    (status)
    );

    lz78_dp #(
        .DICT_LIMIT  (DICT_LIMIT),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
